@@ rtl/core/kmc_pkg.sv @@
package kmc_pkg;

	// Default sizes of the stores.
	localparam int MAX_POINTS_DEF   = 1024;
	localparam int MAX_CLUSTERS_DEF = 16;

	// Fixed field widths.
	localparam int COORD_W  = 16;
	localparam int K_W      = 5;
	localparam int LIMIT_W  = 10;
	localparam int SEED_W   = 10;
	localparam int SLOT_W   = 4;
	localparam int ACTION_W = 2;
	localparam int DIST_W   = 33;

	// Action codes.
	localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SEED = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RUN  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_CLUSTER_COUNT = 1'b0;
	localparam logic CFG_ITER_LIMIT    = 1'b1;

	// Register reset values.
	localparam logic [K_W-1:0]     K_RESET     = 5'd2;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd100;

	// Result status codes.
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic [SEED_W-1:0]         seed_point;
	} in_t;

	typedef struct packed {
		logic [SLOT_W-1:0]         centroid_slot;
		logic signed [COORD_W-1:0] centroid_x;
		logic signed [COORD_W-1:0] centroid_y;
		logic                      status;
		logic                      last;
	} out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic clear;
		logic acc;
		logic wr;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_CLEAR,
		ST_FEED,
		ST_DRAIN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_NEXT_IT,
		ST_EMIT,
		ST_ERR
	} state_t;

endpackage

@@ rtl/core/kmc_ram.sv @@
module kmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/kmc_cell.sv @@
module kmc_cell #(
	parameter int IDX  = 0,
	parameter int CW   = 4,
	parameter int SUMW = 27,
	parameter int CNTW = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kmc_pkg::cell_ctl_t        ctl,
	input  logic                      active,
	input  kmc_pkg::point_t           wr_pt,
	input  kmc_pkg::point_t           acc_pt,
	input  logic                      v_in,
	input  kmc_pkg::point_t           pt_in,
	input  logic [kmc_pkg::DIST_W-1:0] bd_in,
	input  logic [CW-1:0]             bi_in,
	output logic                      v_out,
	output kmc_pkg::point_t           pt_out,
	output logic [kmc_pkg::DIST_W-1:0] bd_out,
	output logic [CW-1:0]             bi_out,
	output logic signed [SUMW-1:0]    sum_x,
	output logic signed [SUMW-1:0]    sum_y,
	output logic [CNTW-1:0]           members,
	output kmc_pkg::point_t           cen
);

	localparam int EXT = SUMW - kmc_pkg::COORD_W;

	logic signed [kmc_pkg::COORD_W:0]     dx, dy;
	logic signed [2*kmc_pkg::COORD_W+1:0] px, py;
	logic [kmc_pkg::DIST_W-2:0]           sqx_s1, sqy_s1;
	logic                                 v_s1;
	kmc_pkg::point_t                      pt_s1;
	logic [kmc_pkg::DIST_W-1:0]           bd_s1;
	logic [CW-1:0]                        bi_s1;
	logic [kmc_pkg::DIST_W-1:0]           d;
	logic                                 take;

	// Squared offsets of the passing point from this centroid.
	always_comb begin
		dx = {pt_in.x[kmc_pkg::COORD_W-1], pt_in.x} - {cen.x[kmc_pkg::COORD_W-1], cen.x};
		dy = {pt_in.y[kmc_pkg::COORD_W-1], pt_in.y} - {cen.y[kmc_pkg::COORD_W-1], cen.y};
		px = dx * dx;
		py = dy * dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		pt_s1  <= pt_in;
		bd_s1  <= bd_in;
		bi_s1  <= bi_in;
		sqx_s1 <= px[kmc_pkg::DIST_W-2:0];
		sqy_s1 <= py[kmc_pkg::DIST_W-2:0];
	end

	// Distance and compare; the first cell always takes, ties keep the earlier one.
	always_comb begin
		d    = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		take = active && ((IDX == 0) || (d < bd_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else begin
			v_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pt_out <= pt_s1;
		bd_out <= take ? d : bd_s1;
		bi_out <= take ? CW'(IDX) : bi_s1;
	end

	// Cluster sums and the centroid held by this cell.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			sum_x   <= '0;
			sum_y   <= '0;
			members <= '0;
		end else if (ctl.acc) begin
			sum_x   <= sum_x + {{EXT{acc_pt.x[kmc_pkg::COORD_W-1]}}, acc_pt.x};
			sum_y   <= sum_y + {{EXT{acc_pt.y[kmc_pkg::COORD_W-1]}}, acc_pt.y};
			members <= members + 1'b1;
		end
		if (ctl.wr) begin
			cen <= wr_pt;
		end
	end

endmodule

@@ rtl/core/kmc_divider.sv @@
module kmc_divider #(
	parameter int SUMW = 27,
	parameter int CNTW = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [SUMW-1:0]           num,
	input  logic [CNTW-1:0]                  den,
	output logic                             done,
	output logic signed [kmc_pkg::COORD_W-1:0] quot
);

	localparam int NW = $clog2(SUMW + 1);

	logic [SUMW-1:0] mag_q;
	logic [CNTW-1:0] rem_q;
	logic            neg_q;
	logic            busy_q;
	logic [NW-1:0]   cnt_q;
	logic [CNTW:0]   trial;
	logic            fit;
	logic [CNTW:0]   diff;

	// One quotient bit per cycle, restoring.
	always_comb begin
		trial = {rem_q, mag_q[SUMW-1]};
		fit   = trial >= {1'b0, den};
		diff  = trial - {1'b0, den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(SUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[SUMW-1] ? -num : num;
			neg_q <= num[SUMW-1];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? diff[CNTW-1:0] : trial[CNTW-1:0];
			mag_q <= {mag_q[SUMW-2:0], fit};
		end
	end

	// Truncation toward zero: divide the magnitude, then restore the sign.
	assign quot = neg_q ? -mag_q[kmc_pkg::COORD_W-1:0] : mag_q[kmc_pkg::COORD_W-1:0];

endmodule

@@ rtl/core/kmeans_clustering.sv @@
// Load: one point per cycle. Seed: a point store read, then a centroid write.
// Run: each iteration streams n points through the cell chain, then updates the k
// centroids one after another in the shared divider pair; results then leave one per
// cycle while out_ready is high. An invalid run gives one result.
// Reset clears the counts and control state and restores the register defaults;
// the point and centroid stores are not cleared.
module kmeans_clustering #(
	parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
	parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kmc_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output kmc_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [kmc_pkg::LIMIT_W-1:0]   cfg_data
);

	localparam int PW   = $clog2(MAX_POINTS);
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int SW   = $clog2(MAX_CLUSTERS + 1);
	localparam int SUMW = kmc_pkg::COORD_W + CNTW;
	localparam int DW   = kmc_pkg::DIST_W;

	kmc_pkg::state_t                state_q, state_d;
	logic [kmc_pkg::K_W-1:0]        k_q;
	logic [kmc_pkg::LIMIT_W-1:0]    limit_q;
	logic [CNTW-1:0]                pts_q, acc_q;
	logic [SW-1:0]                  seeds_q;
	logic [PW-1:0]                  feed_q;
	logic [kmc_pkg::LIMIT_W-1:0]    it_q;
	logic [CW-1:0]                  c_q;
	logic                           changed_q;
	logic                           feed_v_s1;
	logic                           out_valid_q;
	kmc_pkg::out_t                  out_q;

	logic accept, run_bad, seed_ok, last_cell, free;
	logic ram_we, clear_all, div_start, seed_wr, upd_wr, out_load;
	logic [PW-1:0] raddr;
	logic [$bits(kmc_pkg::point_t)-1:0] ram_rdata;
	kmc_pkg::point_t rd_pt, new_pt, wr_pt;

	logic                      c_v  [MAX_CLUSTERS+1];
	kmc_pkg::point_t           c_pt [MAX_CLUSTERS+1];
	logic [DW-1:0]             c_bd [MAX_CLUSTERS+1];
	logic [CW-1:0]             c_bi [MAX_CLUSTERS+1];
	logic signed [SUMW-1:0]    sum_x [MAX_CLUSTERS];
	logic signed [SUMW-1:0]    sum_y [MAX_CLUSTERS];
	logic [CNTW-1:0]           mem   [MAX_CLUSTERS];
	kmc_pkg::point_t           cen   [MAX_CLUSTERS];
	kmc_pkg::cell_ctl_t        ctl   [MAX_CLUSTERS];
	logic                      active [MAX_CLUSTERS];

	logic                              done_x, done_y;
	logic signed [kmc_pkg::COORD_W-1:0] qx, qy;

	// Handshake conditions and run checks.
	always_comb begin
		accept    = in_valid && in_ready;
		run_bad   = (pts_q == '0) || (k_q == '0) || (32'(k_q) > MAX_CLUSTERS) ||
		            (32'(seeds_q) < 32'(k_q)) || (limit_q == '0);
		seed_ok   = (32'(seeds_q) < MAX_CLUSTERS) &&
		            (32'(in_data.seed_point) < 32'(pts_q));
		last_cell = (32'(c_q) == 32'(k_q) - 1);
		free      = !out_valid_q || out_ready;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			kmc_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_data.action)
						kmc_pkg::ACT_SEED: begin
							if (seed_ok) state_d = kmc_pkg::ST_SEED;
						end
						kmc_pkg::ACT_RUN: begin
							state_d = run_bad ? kmc_pkg::ST_ERR : kmc_pkg::ST_CLEAR;
						end
						default: state_d = kmc_pkg::ST_IDLE;
					endcase
				end
			end
			kmc_pkg::ST_SEED:  state_d = kmc_pkg::ST_IDLE;
			kmc_pkg::ST_CLEAR: state_d = kmc_pkg::ST_FEED;
			kmc_pkg::ST_FEED: begin
				if (32'(feed_q) == 32'(pts_q) - 1) state_d = kmc_pkg::ST_DRAIN;
			end
			kmc_pkg::ST_DRAIN: begin
				if (acc_q == pts_q) state_d = kmc_pkg::ST_DIV_START;
			end
			kmc_pkg::ST_DIV_START: state_d = kmc_pkg::ST_DIV_WAIT;
			kmc_pkg::ST_DIV_WAIT: begin
				if (done_x) state_d = last_cell ? kmc_pkg::ST_NEXT_IT : kmc_pkg::ST_DIV_START;
			end
			kmc_pkg::ST_NEXT_IT: begin
				if (!changed_q || (32'(it_q) + 1 == 32'(limit_q))) begin
					state_d = kmc_pkg::ST_EMIT;
				end else begin
					state_d = kmc_pkg::ST_CLEAR;
				end
			end
			kmc_pkg::ST_EMIT: begin
				if (free && last_cell) state_d = kmc_pkg::ST_IDLE;
			end
			kmc_pkg::ST_ERR: begin
				if (free) state_d = kmc_pkg::ST_IDLE;
			end
			default: state_d = kmc_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready  = (state_q == kmc_pkg::ST_IDLE);
		ram_we    = accept && (in_data.action == kmc_pkg::ACT_LOAD) &&
		            (32'(pts_q) < MAX_POINTS);
		raddr     = (state_q == kmc_pkg::ST_FEED) ? feed_q : PW'(in_data.seed_point);
		clear_all = (state_q == kmc_pkg::ST_CLEAR);
		div_start = (state_q == kmc_pkg::ST_DIV_START);
		seed_wr   = (state_q == kmc_pkg::ST_SEED);
		upd_wr    = (state_q == kmc_pkg::ST_DIV_WAIT) && done_x;
		out_load  = ((state_q == kmc_pkg::ST_EMIT) || (state_q == kmc_pkg::ST_ERR)) && free;
	end

	// Point store.
	kmc_ram #(
		.WIDTH($bits(kmc_pkg::point_t)),
		.DEPTH(MAX_POINTS)
	) u_points (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pts_q[PW-1:0]),
		.wdata({in_data.coord_x, in_data.coord_y}),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign rd_pt = kmc_pkg::point_t'(ram_rdata);

	// New centroid for the slot being updated; an empty cluster goes to the origin.
	always_comb begin
		if (mem[c_q] == '0) begin
			new_pt = '0;
		end else begin
			new_pt.x = qx;
			new_pt.y = qy;
		end
		wr_pt = seed_wr ? rd_pt : new_pt;
	end

	// Per-cell decode: accumulate on the winning index, write the chosen slot.
	always_comb begin
		for (int i = 0; i < MAX_CLUSTERS; i++) begin
			active[i]    = (i < 32'(k_q));
			ctl[i].clear = clear_all;
			ctl[i].acc   = c_v[MAX_CLUSTERS] && (32'(c_bi[MAX_CLUSTERS]) == i);
			ctl[i].wr    = (seed_wr && (32'(seeds_q) == i)) || (upd_wr && (32'(c_q) == i));
		end
	end

	// Chain of distance cells; each hands the point and best match to the next.
	assign c_v[0]  = feed_v_s1;
	assign c_pt[0] = rd_pt;
	assign c_bd[0] = '0;
	assign c_bi[0] = '0;

	for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
		kmc_cell #(
			.IDX (g),
			.CW  (CW),
			.SUMW(SUMW),
			.CNTW(CNTW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[g]),
			.active (active[g]),
			.wr_pt  (wr_pt),
			.acc_pt (c_pt[MAX_CLUSTERS]),
			.v_in   (c_v[g]),
			.pt_in  (c_pt[g]),
			.bd_in  (c_bd[g]),
			.bi_in  (c_bi[g]),
			.v_out  (c_v[g+1]),
			.pt_out (c_pt[g+1]),
			.bd_out (c_bd[g+1]),
			.bi_out (c_bi[g+1]),
			.sum_x  (sum_x[g]),
			.sum_y  (sum_y[g]),
			.members(mem[g]),
			.cen    (cen[g])
		);
	end

	// Shared divider pair for the centroid update.
	kmc_divider #(.SUMW(SUMW), .CNTW(CNTW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(sum_x[c_q]), .den(mem[c_q]), .done(done_x), .quot(qx)
	);

	kmc_divider #(.SUMW(SUMW), .CNTW(CNTW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(sum_y[c_q]), .den(mem[c_q]), .done(done_y), .quot(qy)
	);

	// Registers and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kmc_pkg::ST_IDLE;
			k_q         <= kmc_pkg::K_RESET;
			limit_q     <= kmc_pkg::LIMIT_RESET;
			pts_q       <= '0;
			seeds_q     <= '0;
			feed_q      <= '0;
			acc_q       <= '0;
			it_q        <= '0;
			c_q         <= '0;
			changed_q   <= 1'b0;
			feed_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			feed_v_s1 <= (state_q == kmc_pkg::ST_FEED);

			if (cfg_we) begin
				case (cfg_index)
					kmc_pkg::CFG_CLUSTER_COUNT: k_q <= cfg_data[kmc_pkg::K_W-1:0];
					kmc_pkg::CFG_ITER_LIMIT:    limit_q <= cfg_data;
					default: ;
				endcase
			end

			if (ram_we) pts_q <= pts_q + 1'b1;
			if (seed_wr) seeds_q <= seeds_q + 1'b1;

			if (clear_all) begin
				feed_q <= '0;
				acc_q  <= '0;
			end else begin
				if (state_q == kmc_pkg::ST_FEED) feed_q <= feed_q + 1'b1;
				if (c_v[MAX_CLUSTERS]) acc_q <= acc_q + 1'b1;
			end

			if (accept && (in_data.action == kmc_pkg::ACT_RUN)) begin
				it_q <= '0;
			end else if (state_q == kmc_pkg::ST_NEXT_IT) begin
				it_q <= it_q + 1'b1;
			end

			if ((state_q == kmc_pkg::ST_DRAIN) || (state_q == kmc_pkg::ST_NEXT_IT)) begin
				c_q <= '0;
			end else if ((upd_wr || (out_load && state_q == kmc_pkg::ST_EMIT)) && !last_cell) begin
				c_q <= c_q + 1'b1;
			end

			if (state_q == kmc_pkg::ST_DRAIN) begin
				changed_q <= 1'b0;
			end else if (upd_wr && (new_pt != cen[c_q])) begin
				changed_q <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == kmc_pkg::ST_ERR) begin
				out_q.centroid_slot <= '0;
				out_q.centroid_x    <= '0;
				out_q.centroid_y    <= '0;
				out_q.status        <= kmc_pkg::STATUS_BAD;
				out_q.last          <= 1'b1;
			end else begin
				out_q.centroid_slot <= kmc_pkg::SLOT_W'(c_q);
				out_q.centroid_x    <= cen[c_q].x;
				out_q.centroid_y    <= cen[c_q].y;
				out_q.status        <= kmc_pkg::STATUS_OK;
				out_q.last          <= last_cell;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks on the sequencer and datapath.
	assert property (@(posedge clk) disable iff (!arst_n) acc_q <= pts_q)
		else $error("more points accumulated than loaded");
	assert property (@(posedge clk) disable iff (!arst_n) out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while occupied");
	assert property (@(posedge clk) disable iff (!arst_n) 32'(seeds_q) <= MAX_CLUSTERS)
		else $error("seed count beyond cell count");
	assert property (@(posedge clk) disable iff (!arst_n) done_x == done_y)
		else $error("divider pair out of step");

endmodule

@@ tb/testbench.sv @@
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = kmc_pkg::MAX_POINTS_DEF;
	localparam int NCL  = kmc_pkg::MAX_CLUSTERS_DEF;
	localparam int STALL_LIMIT = 4000000;
	localparam int QUIET_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	kmc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	kmc_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = kmc_pkg::CFG_CLUSTER_COUNT;
	logic [kmc_pkg::LIMIT_W-1:0] cfg_data = '0;

	kmeans_clustering uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Own copy of the clustering state.
	shortint pt_x[NPTS];
	shortint pt_y[NPTS];
	int n_points;
	shortint cen_x[NCL];
	shortint cen_y[NCL];
	int n_seeds;
	int k_reg;
	int limit_reg;
	kmc_pkg::out_t centroid_q[$];

	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int runs_sent = 0;
	bit steady = 1'b0;
	int stall_count = 0;

	// One assignment and update pass; returns whether any centroid moved.
	function automatic bit lloyd_pass(int k);
		longint sx[NCL];
		longint sy[NCL];
		int cnt[NCL];
		longint dx, dy, d, bestd;
		int best;
		shortint nx, ny;
		bit moved;
		moved = 1'b0;
		for (int c = 0; c < NCL; c++) begin
			sx[c] = 0; sy[c] = 0; cnt[c] = 0;
		end
		for (int i = 0; i < n_points; i++) begin
			best = 0;
			bestd = -1;
			for (int c = 0; c < k; c++) begin
				dx = longint'(pt_x[i]) - longint'(cen_x[c]);
				dy = longint'(pt_y[i]) - longint'(cen_y[c]);
				d = dx * dx + dy * dy;
				if (c == 0 || d < bestd) begin
					bestd = d;
					best = c;
				end
			end
			sx[best] += pt_x[i];
			sy[best] += pt_y[i];
			cnt[best]++;
		end
		for (int c = 0; c < k; c++) begin
			nx = 0; ny = 0;
			if (cnt[c] > 0) begin
				nx = shortint'(sx[c] / longint'(cnt[c]));
				ny = shortint'(sy[c] / longint'(cnt[c]));
			end
			if (nx != cen_x[c] || ny != cen_y[c]) moved = 1'b1;
			cen_x[c] = nx;
			cen_y[c] = ny;
		end
		return moved;
	endfunction

	// Works out the centroids that one accepted item causes.
	function automatic void predict_centroids(kmc_pkg::in_t it);
		kmc_pkg::out_t r;
		case (it.action)
			kmc_pkg::ACT_LOAD: begin
				if (n_points < NPTS) begin
					pt_x[n_points] = it.coord_x;
					pt_y[n_points] = it.coord_y;
					n_points++;
				end
			end
			kmc_pkg::ACT_SEED: begin
				if (n_seeds < NCL && int'(it.seed_point) < n_points) begin
					cen_x[n_seeds] = pt_x[it.seed_point];
					cen_y[n_seeds] = pt_y[it.seed_point];
					n_seeds++;
				end
			end
			kmc_pkg::ACT_RUN: begin
				if (n_points == 0 || k_reg == 0 || k_reg > NCL || n_seeds < k_reg ||
				    limit_reg == 0) begin
					r = '0;
					r.status = kmc_pkg::STATUS_BAD;
					r.last = 1'b1;
					centroid_q = {centroid_q, r};
				end else begin
					for (int i = 0; i < limit_reg; i++)
						if (!lloyd_pass(k_reg)) break;
					for (int c = 0; c < k_reg; c++) begin
						r.centroid_slot = c[kmc_pkg::SLOT_W-1:0];
						r.centroid_x = cen_x[c];
						r.centroid_y = cen_y[c];
						r.status = kmc_pkg::STATUS_OK;
						r.last = (c + 1 == k_reg);
						centroid_q = {centroid_q, r};
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Sends one item; valid is left high so that back-to-back transfers need no gap.
	task automatic send_item(kmc_pkg::in_t it);
		while (!steady && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_centroids(it);
		items_sent++;
		if (it.action == kmc_pkg::ACT_RUN) runs_sent++;
	endtask

	task automatic send_op(logic [kmc_pkg::ACTION_W-1:0] act, int x, int y, int sp);
		kmc_pkg::in_t it;
		it.action = act;
		it.coord_x = x[kmc_pkg::COORD_W-1:0];
		it.coord_y = y[kmc_pkg::COORD_W-1:0];
		it.seed_point = sp[kmc_pkg::SEED_W-1:0];
		send_item(it);
	endtask

	// Waits until every expected centroid has arrived and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (centroid_q.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[kmc_pkg::LIMIT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == kmc_pkg::CFG_CLUSTER_COUNT) k_reg = value & 5'h1f;
		else limit_reg = value & 10'h3ff;
	endtask

	// Result side: compare each transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (centroid_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", out_data);
			end else begin
				if (out_data !== centroid_q[0]) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp slot %0d x %0d y %0d st %0d last %0d, ",
							"got slot %0d x %0d y %0d st %0d last %0d"},
							centroid_q[0].centroid_slot, centroid_q[0].centroid_x,
							centroid_q[0].centroid_y, centroid_q[0].status,
							centroid_q[0].last, out_data.centroid_slot,
							out_data.centroid_x, out_data.centroid_y,
							out_data.status, out_data.last);
				end
				void'(centroid_q.pop_front());
			end
		end
		out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 32);
	end

	// Watchdog over cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Runs with nothing loaded, a seed of an unloaded point and an unused action.
	task automatic test_empty_store();
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		send_op(kmc_pkg::ACT_SEED, 0, 0, 0);
		send_op(2'd3, -1, -1, 1023);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
	endtask

	// Extreme coordinates and invalid register settings: cluster counts 0, 3 and 17, limit 0.
	task automatic test_extremes();
		send_op(kmc_pkg::ACT_LOAD, -32768, -32768, 0);
		send_op(kmc_pkg::ACT_LOAD, 32767, 32767, 1023);
		send_op(kmc_pkg::ACT_LOAD, 0, 0, 0);
		send_op(kmc_pkg::ACT_LOAD, -32768, 32767, 0);
		send_op(kmc_pkg::ACT_LOAD, 100, -5, 0);
		send_op(kmc_pkg::ACT_SEED, 0, 0, 0);
		send_op(kmc_pkg::ACT_SEED, 0, 0, 1);
		send_op(kmc_pkg::ACT_SEED, 0, 0, 1023);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		write_reg(kmc_pkg::CFG_CLUSTER_COUNT, 1);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		write_reg(kmc_pkg::CFG_CLUSTER_COUNT, 3);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		write_reg(kmc_pkg::CFG_CLUSTER_COUNT, 0);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		write_reg(kmc_pkg::CFG_CLUSTER_COUNT, 17);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		write_reg(kmc_pkg::CFG_CLUSTER_COUNT, 2);
		write_reg(kmc_pkg::CFG_ITER_LIMIT, 0);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		write_reg(kmc_pkg::CFG_ITER_LIMIT, 1);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		write_reg(kmc_pkg::CFG_ITER_LIMIT, 1023);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		settle();
	endtask

	// Random mix, about half of it points scattered around a few centres.
	task automatic test_random_mix();
		int sel, cx, cy, spread;
		cx = 0; cy = 0;
		for (int n = 0; n < 110; n++) begin
			steady = (n >= 40 && n < 60);
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				if ($urandom_range(0, 9) == 0) begin
					send_op(kmc_pkg::ACT_LOAD, $urandom, $urandom, $urandom);
				end else begin
					if ($urandom_range(0, 5) == 0) begin
						cx = $urandom_range(0, 60000) - 30000;
						cy = $urandom_range(0, 60000) - 30000;
					end
					spread = $urandom_range(0, 2000);
					send_op(kmc_pkg::ACT_LOAD, cx + $urandom_range(0, 2 * spread) - spread,
						cy + $urandom_range(0, 2 * spread) - spread, $urandom);
				end
			end else if (sel < 65) begin
				if ($urandom_range(0, 3) == 0)
					send_op(kmc_pkg::ACT_SEED, $urandom, $urandom, $urandom);
				else
					send_op(kmc_pkg::ACT_SEED, $urandom, $urandom,
						$urandom_range(0, n_points));
			end else if (sel < 72) begin
				send_op(2'd3, $urandom, $urandom, $urandom);
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					sel = $urandom_range(0, 9);
					if (sel == 0) write_reg(kmc_pkg::CFG_CLUSTER_COUNT, $urandom_range(0, 31));
					else if (sel == 1) write_reg(kmc_pkg::CFG_CLUSTER_COUNT, NCL);
					else write_reg(kmc_pkg::CFG_CLUSTER_COUNT,
						$urandom_range(1, (n_seeds > 0) ? n_seeds : 1));
					sel = $urandom_range(0, 9);
					if (sel == 0) write_reg(kmc_pkg::CFG_ITER_LIMIT, 1023);
					else write_reg(kmc_pkg::CFG_ITER_LIMIT, $urandom_range(1, 20));
				end
				send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
			end
		end
		steady = 1'b0;
		settle();
	endtask

	// Fills the point store past its end and overfills the seeds.
	task automatic test_full_stores();
		int extra;
		extra = NPTS + 4 - n_points;
		steady = 1'b1;
		for (int i = 0; i < extra; i++)
			send_op(kmc_pkg::ACT_LOAD, $urandom_range(0, 8000) - 4000,
				$urandom_range(0, 8000) - 4000, 0);
		steady = 1'b0;
		for (int s = 0; s < NCL + 2; s++)
			send_op(kmc_pkg::ACT_SEED, 0, 0, $urandom_range(0, NPTS - 1));
		write_reg(kmc_pkg::CFG_CLUSTER_COUNT, NCL);
		write_reg(kmc_pkg::CFG_ITER_LIMIT, 3);
		send_op(kmc_pkg::ACT_RUN, 0, 0, 0);
		settle();
	endtask

	initial begin
		n_points = 0;
		n_seeds = 0;
		k_reg = kmc_pkg::K_RESET;
		limit_reg = kmc_pkg::LIMIT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_extremes();
		test_random_mix();
		test_full_stores();
		settle();
		repeat (100) @(posedge clk);
		$display("Covered %0d items and %0d runs, %0d centroid results checked.",
			items_sent, runs_sent, results_seen);
		$display("Points held %0d, seeds held %0d, last cluster count %0d.",
			n_points, n_seeds, k_reg);
		if (errors == 0 && centroid_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/kmc_pkg.sv
rtl/core/kmc_ram.sv
rtl/core/kmc_cell.sv
rtl/core/kmc_divider.sv
rtl/core/kmeans_clustering.sv
tb/testbench.sv
